/* design/kcs_pkg.sv */
`default_nettype none
package kcs_pkg;

  localparam int MAX_KEYS_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int FRAC_W       = 16;
  localparam int IDX_W        = 4;
  localparam int CNT_W        = 5;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

endpackage
`default_nettype wire

/* design/kcs_div.sv */
`default_nettype none
module kcs_div import kcs_pkg::*; (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  input  wire  [DATA_W-1:0] num,
  input  wire  [DATA_W-1:0] den,
  output logic              done,
  output logic [FRAC_W-1:0] quo
);

  localparam int STEP_W = $clog2(FRAC_W);

  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dvs;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  // restoring division, one quotient bit per cycle
  assign shifted = {rem, 1'b0};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (step == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (step == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dvs  <= den;
      step <= STEP_W'(FRAC_W - 1);
    end else if (busy) begin
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[FRAC_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DATA_W-1:0];
        quo <= {quo[FRAC_W-2:0], 1'b0};
      end
      step <= step - 1'b1;
    end
  end

endmodule
`default_nettype wire

/* design/keyframe_curve_sampler.sv */
// keyframe write: the input stays unstalled, next item taken at the following edge
// sample: a serial time-table scan finds the interval, then the 16-step divider forms
// the fraction; when no interval matches, the value of the last active key is returned;
// one sample in flight at a time, input released in the same cycle the result rises;
// a finished result may wait in the output register
// reset: key_count returns to 1, control and output valid clear, key tables keep contents
`default_nettype none
module keyframe_curve_sampler import kcs_pkg::*; #(
  parameter int MAX_KEYS = MAX_KEYS_DEF
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      cfg_wen,
  input  wire        [CNT_W-1:0]   cfg_wdata,
  input  wire                      item_valid,
  output logic                     item_stall,
  input  wire                      cmd,
  input  wire        [IDX_W-1:0]   key_index,
  input  wire signed [DATA_W-1:0]  key_time,
  input  wire signed [DATA_W-1:0]  key_value,
  input  wire signed [DATA_W-1:0]  position,
  output logic                     result_valid,
  input  wire                      result_stall,
  output logic signed [DATA_W-1:0] sample_value,
  output logic                     past_keys
);

  localparam int ADDR_W = $clog2(MAX_KEYS);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_SCAN  = 11'b00000000010,
    S_VRD0  = 11'b00000000100,
    S_VRD1  = 11'b00000001000,
    S_VRD2  = 11'b00000010000,
    S_DIV   = 11'b00000100000,
    S_MUL   = 11'b00001000000,
    S_SUM   = 11'b00010000000,
    S_VLAST = 11'b00100000000,
    S_LASTW = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t state, state_next;

  logic [DATA_W-1:0] time_mem  [MAX_KEYS];
  logic [DATA_W-1:0] value_mem [MAX_KEYS];

  logic [CNT_W-1:0]         key_count;
  logic [ADDR_W-1:0]        last_calc;
  logic [ADDR_W-1:0]        last_idx;
  logic [ADDR_W-1:0]        scan_idx;
  logic [ADDR_W-1:0]        k_idx;
  logic [ADDR_W-1:0]        t_addr;
  logic [ADDR_W-1:0]        v_addr;
  logic signed [DATA_W-1:0] time_rd;
  logic signed [DATA_W-1:0] value_rd;
  logic signed [DATA_W-1:0] pos;
  logic signed [DATA_W-1:0] t0;
  logic signed [DATA_W-1:0] t1;
  logic signed [DATA_W-1:0] v0;
  logic signed [DATA_W-1:0] v1;
  logic signed [DATA_W:0]   dv;
  logic signed [DATA_W+FRAC_W+1:0] prod;
  logic signed [DATA_W-1:0] res;
  logic                     flag;
  logic                     take;
  logic                     mem_we;
  logic                     hit;
  logic                     out_free;
  logic                     div_start;
  logic                     div_done;
  logic [FRAC_W-1:0]        quo;
  logic [DATA_W-1:0]        div_num;
  logic [DATA_W-1:0]        div_den;

  assign item_stall = (state != S_IDLE);
  assign take       = item_valid && !item_stall;
  assign mem_we     = take && (cmd == CMD_WRITE) && (int'(key_index) < MAX_KEYS);
  assign hit        = (scan_idx != '0) && (t0 <= pos) && (pos < time_rd);
  assign out_free   = !result_valid || !result_stall;
  assign div_start  = (state == S_VRD2);
  assign div_num    = pos - t0;
  assign div_den    = t1 - t0;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= CNT_W'(1);
    end else if (cfg_wen) begin
      key_count <= cfg_wdata;
    end
  end

  always_comb begin
    if (key_count == '0) begin
      last_calc = '0;
    end else if (int'(key_count) > MAX_KEYS) begin
      last_calc = ADDR_W'(MAX_KEYS - 1);
    end else begin
      last_calc = ADDR_W'(key_count - CNT_W'(1));
    end
  end

  always_comb begin
    case (state)
      S_SCAN:  t_addr = scan_idx + 1'b1;
      default: t_addr = '0;
    endcase
  end

  always_comb begin
    case (state)
      S_VRD1:  v_addr = k_idx + 1'b1;
      S_VLAST: v_addr = last_idx;
      default: v_addr = k_idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      time_mem[ADDR_W'(key_index)] <= key_time;
    end
    time_rd <= time_mem[t_addr];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      value_mem[ADDR_W'(key_index)] <= key_value;
    end
    value_rd <= value_mem[v_addr];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (take && (cmd == CMD_SAMPLE)) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (hit) begin
          state_next = S_VRD0;
        end else if (scan_idx == last_idx) begin
          state_next = S_VLAST;
        end
      end
      S_VRD0:  state_next = S_VRD1;
      S_VRD1:  state_next = S_VRD2;
      S_VRD2:  state_next = S_DIV;
      S_DIV: begin
        if (div_done) state_next = S_MUL;
      end
      S_MUL:   state_next = S_SUM;
      S_SUM:   state_next = S_DONE;
      S_VLAST: state_next = S_LASTW;
      S_LASTW: state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // interval search and arithmetic datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        scan_idx <= '0;
        last_idx <= last_calc;
        pos      <= position;
      end
      S_SCAN: begin
        if (hit) begin
          k_idx <= scan_idx - 1'b1;
          t1    <= time_rd;
        end else begin
          t0       <= time_rd;
          scan_idx <= scan_idx + 1'b1;
        end
      end
      S_VRD1:  v0 <= value_rd;
      S_VRD2:  v1 <= value_rd;
      S_MUL:   prod <= dv * $signed({1'b0, quo});
      S_SUM: begin
        res  <= v0 + prod[DATA_W+FRAC_W-1:FRAC_W];
        flag <= 1'b0;
      end
      S_LASTW: begin
        res  <= value_rd;
        flag <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign dv = {v1[DATA_W-1], v1} - {v0[DATA_W-1], v0};

  kcs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      sample_value <= res;
      past_keys    <= flag;
    end
  end

endmodule
`default_nettype wire

/* design/kcs_check.sv */
`default_nettype none
module kcs_check import kcs_pkg::*; (
  input wire              clk,
  input wire              rst,
  input wire              item_valid,
  input wire              item_stall,
  input wire              cmd,
  input wire              result_valid,
  input wire              result_stall,
  input wire [DATA_W-1:0] sample_value,
  input wire              past_keys
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(sample_value) && $stable(past_keys))
    else $error("stalled result changed");

  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && (cmd == CMD_SAMPLE) |=> item_stall)
    else $error("sample transfer did not occupy the block");

  a_write_quick: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && (cmd == CMD_WRITE) |=> !item_stall)
    else $error("key write held the input");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_stall))
    else $error("result appeared without a sample in progress");

endmodule

bind keyframe_curve_sampler kcs_check u_check (.*);
`default_nettype wire

/* test/keyframe_curve_sampler_test.sv */
`timescale 1ns / 1ps
module keyframe_curve_sampler_test;
  import kcs_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned SETTLE       = 4;
  localparam int unsigned TAIL         = 60;

  typedef struct packed {
    logic              cmd;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] ktime;
    logic [DATA_W-1:0] kval;
    logic [DATA_W-1:0] pos;
  } curve_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              past;
  } curve_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    curve_item_t   item;
    logic [CNT_W-1:0] len;
    logic          typed;
    curve_result_t want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wen = 1'b0;
  logic [CNT_W-1:0]  cfg_wdata = '0;
  logic              item_valid = 1'b0;
  logic              item_stall;
  logic              cmd = CMD_WRITE;
  logic [IDX_W-1:0]  key_index = '0;
  logic [DATA_W-1:0] key_time = '0;
  logic [DATA_W-1:0] key_value = '0;
  logic [DATA_W-1:0] position = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic [DATA_W-1:0] sample_value;
  logic              past_keys;

  // shadow of the curve table and the key count
  logic [DATA_W-1:0] time_tab [MAX_KEYS_DEF];
  logic [DATA_W-1:0] value_tab [MAX_KEYS_DEF];
  logic [CNT_W-1:0]  curve_len = 1;

  curve_result_t pending_samples [$];
  stim_row_t     script [$];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned items_sent = 0;
  int unsigned samples_checked = 0;
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;
  bit          hold_on = 1'b0;
  event        hold_start;

  keyframe_curve_sampler #(.MAX_KEYS(MAX_KEYS_DEF)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .cmd          (cmd),
    .key_index    (key_index),
    .key_time     (key_time),
    .key_value    (key_value),
    .position     (position),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sample_value (sample_value),
    .past_keys    (past_keys)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout at %0t, %0d samples still pending", $time, pending_samples.size());
      $display("keyframe_curve_sampler_test: done, errors");
      $finish;
    end
  end

  // receiver hold-off, counted here
  initial begin
    forever begin
      @(hold_start);
      hold_on = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_on = 1'b0;
    end
  end

  always @(posedge clk) begin
    curve_result_t exp_res;
    if (!rst && result_valid && !result_stall) begin
      if (pending_samples.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected result value %h past %b", $time, sample_value, past_keys);
      end else begin
        exp_res = pending_samples.pop_front();
        samples_checked++;
        if (sample_value !== exp_res.value) begin
          fault_count++;
          $display("%0t: sample_value expected %h actual %h", $time, exp_res.value,
                   sample_value);
        end
        if (past_keys !== exp_res.past) begin
          fault_count++;
          $display("%0t: past_keys expected %b actual %b", $time, exp_res.past, past_keys);
        end
      end
    end
    result_stall <= hold_on || ($urandom_range(0, 99) < rx_idle_pct);
  end

  function automatic int unsigned active_len();
    if (curve_len == 0) return 1;
    if (curve_len > MAX_KEYS_DEF) return MAX_KEYS_DEF;
    return curve_len;
  endfunction

  function automatic curve_result_t interpolate(input logic [DATA_W-1:0] pos_bits);
    curve_result_t res;
    int unsigned   n;
    int unsigned   k;
    longint        p;
    longint        t0;
    longint        t1;
    longint        frac;
    longint        dv;
    longint        lift;
    bit            hit;
    n = active_len();
    p = longint'($signed(pos_bits));
    res.value = value_tab[n-1];
    res.past = 1'b1;
    hit = 1'b0;
    for (k = 0; k + 1 < n && !hit; k++) begin
      t0 = longint'($signed(time_tab[k]));
      t1 = longint'($signed(time_tab[k+1]));
      if (t0 <= p && p < t1) begin
        frac = ((p - t0) <<< FRAC_W) / (t1 - t0);
        dv = longint'($signed(value_tab[k+1])) - longint'($signed(value_tab[k]));
        lift = (dv * frac) >>> FRAC_W;
        res.value = DATA_W'(longint'($signed(value_tab[k])) + lift);
        res.past = 1'b0;
        hit = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic logic [DATA_W-1:0] pick_position(input int unsigned n);
    int unsigned k;
    longint      t0;
    longint      t1;
    k = $urandom_range(0, n - 1);
    t0 = longint'($signed(time_tab[k]));
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return time_tab[k];
      2: return time_tab[0] - $urandom_range(1, 32'h0002_0000);
      3: return time_tab[n-1] + $urandom_range(0, 32'h0002_0000);
      default: begin
        if (k + 1 < n) begin
          t1 = longint'($signed(time_tab[k+1]));
          if (t1 > t0) return DATA_W'(t0 + (longint'($urandom) % (t1 - t0)));
        end
        return DATA_W'(t0 + $urandom_range(0, 32'h0001_0000));
      end
    endcase
  endfunction

  function automatic curve_item_t make_item(input logic c, input logic [IDX_W-1:0] i,
                                            input logic [DATA_W-1:0] t,
                                            input logic [DATA_W-1:0] v,
                                            input logic [DATA_W-1:0] p);
    curve_item_t it;
    it.cmd = c;
    it.idx = i;
    it.ktime = t;
    it.kval = v;
    it.pos = p;
    return it;
  endfunction

  function automatic stim_row_t item_row(input logic c, input logic [IDX_W-1:0] i,
                                         input logic [DATA_W-1:0] t,
                                         input logic [DATA_W-1:0] v,
                                         input logic [DATA_W-1:0] p);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.item = make_item(c, i, t, v, p);
    return r;
  endfunction

  function automatic stim_row_t typed_sample(input logic [DATA_W-1:0] p,
                                             input logic [DATA_W-1:0] v, input logic past);
    stim_row_t r;
    r = item_row(CMD_SAMPLE, '0, '0, '0, p);
    r.typed = 1'b1;
    r.want.value = v;
    r.want.past = past;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CNT_W-1:0] len);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.len = len;
    return r;
  endfunction

  function automatic curve_item_t random_sample();
    return make_item(CMD_SAMPLE, IDX_W'($urandom), $urandom, $urandom,
                     pick_position(active_len()));
  endfunction

  task automatic offer(input curve_item_t it, input logic typed, input curve_result_t want);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    item_valid <= 1'b1;
    cmd <= it.cmd;
    key_index <= it.idx;
    key_time <= it.ktime;
    key_value <= it.kval;
    position <= it.pos;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
    if (it.cmd == CMD_WRITE) begin
      time_tab[it.idx] = it.ktime;
      value_tab[it.idx] = it.kval;
    end else begin
      pending_samples.push_back(typed ? want : interpolate(it.pos));
    end
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_key_count(input logic [CNT_W-1:0] len);
    wait_idle();
    cfg_wen <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    curve_len = len;
    cfg_wen <= 1'b0;
  endtask

  task automatic curve_chunk();
    logic [CNT_W-1:0] len_code;
    int unsigned      n;
    int unsigned      shots;
    int unsigned      k;
    longint           stamp;
    logic [DATA_W-1:0] kv;
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 9))
        0: len_code = 0;
        1: len_code = CNT_W'($urandom_range(MAX_KEYS_DEF + 1, 31));
        2: len_code = CNT_W'(MAX_KEYS_DEF);
        default: len_code = CNT_W'($urandom_range(1, MAX_KEYS_DEF));
      endcase
      load_key_count(len_code);
    end
    n = active_len();
    if ($urandom_range(0, 1) == 0) begin
      if ($urandom_range(0, 3) == 0) stamp = longint'($signed($urandom));
      else stamp = longint'($urandom_range(0, 32'h0020_0000)) - 64'sh0010_0000;
      for (k = 0; k < n; k++) begin
        kv = ($urandom_range(0, 2) == 0) ? $urandom : DATA_W'($urandom_range(0, 32'h0004_0000)
             - 32'h0002_0000);
        offer(make_item(CMD_WRITE, IDX_W'(k), DATA_W'(stamp), kv, $urandom), 1'b0, '0);
        case ($urandom_range(0, 15))
          0: stamp += 0;
          1: stamp -= $urandom_range(1, 32'h0004_0000);
          2: stamp += longint'($urandom);
          default: stamp += $urandom_range(1, 32'h0004_0000);
        endcase
      end
    end
    // stray write that may break the ordering
    if ($urandom_range(0, 3) == 0)
      offer(make_item(CMD_WRITE, IDX_W'($urandom), $urandom, $urandom, $urandom), 1'b0, '0);
    shots = $urandom_range(1, 6);
    repeat (shots) offer(random_sample(), 1'b0, '0);
    if ($urandom_range(0, 15) == 0) wait_idle();
  endtask

  task automatic run_phase(input int unsigned tx_pct, input int unsigned rx_pct,
                           input int unsigned quota);
    int unsigned start;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start = items_sent;
    while (items_sent - start < quota) curve_chunk();
  endtask

  initial begin
    int unsigned k;
    logic [DATA_W-1:0] slot_time;
    for (k = 0; k < MAX_KEYS_DEF; k++) begin
      time_tab[k] = '0;
      value_tab[k] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    script.push_back(item_row(CMD_WRITE, 0, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000));
    script.push_back(typed_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
    script.push_back(item_row(CMD_WRITE, 1, 32'h0001_0000, 32'h8000_0000, 32'h5555_5555));
    script.push_back(cfg_row(2));
    script.push_back(typed_sample(32'h0000_0000, 32'h7FFF_FFFF, 1'b0));
    script.push_back(typed_sample(32'h0001_0000, 32'h8000_0000, 1'b1));
    script.push_back(item_row(CMD_SAMPLE, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_8000));
    script.push_back(item_row(CMD_SAMPLE, 0, 32'h0, 32'h0, 32'h0000_FFFF));
    script.push_back(typed_sample(32'hFFFF_FFFF, 32'h8000_0000, 1'b1));
    script.push_back(cfg_row(0));
    script.push_back(typed_sample(32'h1234_5678, 32'h7FFF_FFFF, 1'b1));
    for (k = 2; k < MAX_KEYS_DEF; k++) begin
      // slot 9 steps backwards, slot 12 repeats slot 11
      if (k == 9) slot_time = 32'h0002_0000;
      else if (k == 12) slot_time = 32'h000B_0000;
      else if (k == MAX_KEYS_DEF - 1) slot_time = 32'h7FFF_FFFF;
      else slot_time = k << FRAC_W;
      script.push_back(item_row(CMD_WRITE, IDX_W'(k), slot_time,
                                k[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, 32'hAAAA_AAAA));
    end
    script.push_back(cfg_row(31));
    script.push_back(item_row(CMD_SAMPLE, 0, 32'h0, 32'h0, 32'h7FFF_FFFE));
    script.push_back(typed_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b1));

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) load_key_count(script[i].len);
      else offer(script[i].item, script[i].typed, script[i].want);
    end

    // fill the block while the receiver holds off
    tx_idle_pct = 16;
    rx_idle_pct = 64;
    wait_idle();
    -> hold_start;
    repeat (8) offer(random_sample(), 1'b0, '0);

    run_phase(16, 64, 200);
    run_phase(64, 16, 200);
    run_phase(0, 0, 200);

    load_key_count(1);
    offer(random_sample(), 1'b0, '0);

    wait_idle();
    repeat (TAIL) @(posedge clk);
    $display("%0d transfers in, %0d samples checked, %0d faults", items_sent,
             samples_checked, fault_count);
    $display("curves of 1 to 16 keys, key count 0 and saturated, unordered times, stalls");
    if (fault_count == 0 && pending_samples.size() == 0) begin
      $display("keyframe_curve_sampler_test: done, clean");
    end else begin
      $display("keyframe_curve_sampler_test: done, errors");
    end
    $finish;
  end

endmodule

/* keyframe_curve_sampler.f */
design/kcs_pkg.sv
design/kcs_div.sv
design/keyframe_curve_sampler.sv
design/kcs_check.sv
test/keyframe_curve_sampler_test.sv
